[rtl/tts_pkg.sv]
package tts_pkg;

    localparam int unsigned MaxTimersDefault = 16;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_EXECUTE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_ADDED     = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_CANCELLED = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_CLEARED   = 3'd5,
        KIND_WAIT      = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FIRE,
        ST_WAIT_OUT
    } t_state;

endpackage

[rtl/timer_table_scheduler.sv]
// Timer table scheduler. Add, cancel, cancel-all and execute commands are
// taken while busy is low; each yields results on the o_ ports, marked by
// o_valid, and the receiver cannot stall them. Add and cancel-all give
// their result in the cycle after acceptance with no scan. Cancel and
// execute scan the entry memory one entry per cycle through its single read
// port, and an execute scans it again after each timer that it fires and
// ends with a wait result.
module timer_table_scheduler
    import tts_pkg::*;
#(
    parameter int unsigned MAX_TIMERS = MaxTimersDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_timeout_ms,
    input  logic [15:0] i_owner,
    input  logic [15:0] i_timer_id,
    input  logic        i_periodic,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [15:0] o_event_owner,
    output logic [15:0] o_event_id,
    output logic [31:0] o_wait_ms,
    output logic        o_last
);

    localparam int unsigned IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int unsigned CW = $clog2(MAX_TIMERS + 1);

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] period;
        logic [15:0] owner;
        logic [15:0] ident;
        logic        repeat_en;
        logic [31:0] order;
    } t_entry;

    // Entry memory, one read and one write port, registered read.
    t_entry mem [MAX_TIMERS];
    t_entry r_rd;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    t_state r_state, n_state;
    logic [MAX_TIMERS-1:0] r_valid, n_valid;
    logic [MAX_TIMERS-1:0] r_fired, n_fired;   // reloaded or fired during this execute
    logic [31:0] r_counter, n_counter;
    logic [1:0]  r_cmd;
    logic [31:0] r_now;
    logic [15:0] r_own, r_id;
    logic [CW-1:0] r_cnt, n_cnt;      // read address counter
    logic [IW-1:0] r_ridx, n_ridx;    // index of data in r_rd
    logic          r_rdv, n_rdv;
    logic          r_found, n_found;
    logic [IW-1:0] r_best, n_best;
    t_entry        r_bent, n_bent;
    logic          r_wfound, n_wfound; // earliest valid expiry for the wait
    logic [31:0]   r_wmin, n_wmin;

    logic        n_ov;
    logic [2:0]  n_kind;
    logic [15:0] n_eo, n_ei;
    logic [31:0] n_wt;
    logic        n_last;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    logic [IW-1:0] free_idx;
    logic          free_ok;
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    logic cand, better;
    always_comb begin
        cand = 1'b0;
        if (r_rdv && r_valid[r_ridx]) begin
            if (r_cmd == CMD_CANCEL) begin
                cand = (r_rd.owner == r_own) && (r_rd.ident == r_id);
            end else begin
                cand = !r_fired[r_ridx] && (r_rd.expiry <= r_now);
            end
        end
        if (r_rd.expiry != r_bent.expiry) begin
            better = r_rd.expiry < r_bent.expiry;
        end else begin
            better = r_rd.order < r_bent.order;
        end
        better = better || !r_found;
    end

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_fired   = r_fired;
        n_counter = r_counter;
        n_cnt     = r_cnt;
        n_ridx    = r_cnt[IW-1:0];
        n_rdv     = 1'b0;
        n_found   = r_found;
        n_best    = r_best;
        n_bent    = r_bent;
        n_wfound  = r_wfound;
        n_wmin    = r_wmin;
        rd_addr   = r_cnt[IW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_best;
        wr_data   = r_bent;
        n_ov      = 1'b0;
        n_kind    = KIND_ADDED;
        n_eo      = '0;
        n_ei      = '0;
        n_wt      = '0;
        n_last    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cnt    = '0;
                    n_found  = 1'b0;
                    n_wfound = 1'b0;
                    n_fired  = '0;
                    unique case (t_cmd'(i_command))
                        CMD_ADD: begin
                            n_ov = 1'b1;
                            if (free_ok) begin
                                wr_en   = 1'b1;
                                wr_addr = free_idx;
                                wr_data = '{expiry: sat_add(i_now_ms, i_timeout_ms),
                                            period: i_timeout_ms, owner: i_owner,
                                            ident: i_timer_id, repeat_en: i_periodic,
                                            order: r_counter};
                                n_valid[free_idx] = 1'b1;
                                n_counter = r_counter + 32'd1;
                                n_kind = KIND_ADDED;
                            end else begin
                                n_kind = KIND_FULL;
                            end
                        end
                        CMD_CLEAR: begin
                            n_ov    = 1'b1;
                            n_valid = '0;
                            n_kind  = KIND_CLEARED;
                        end
                        default: n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_cnt < CW'(MAX_TIMERS)) begin
                    n_rdv = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    n_state = ST_LAST;
                end
                if (cand && better) begin
                    n_found = 1'b1;
                    n_best  = r_ridx;
                    n_bent  = r_rd;
                end
                // Earliest expiry among valid entries for the final wait.
                if (r_rdv && r_valid[r_ridx] && (!r_wfound || r_rd.expiry < r_wmin)) begin
                    n_wfound = 1'b1;
                    n_wmin   = r_rd.expiry;
                end
            end
            ST_LAST: begin
                if (r_cmd == CMD_CANCEL) begin
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                    if (r_found) begin
                        n_valid[r_best] = 1'b0;
                        n_kind = KIND_CANCELLED;
                    end else begin
                        n_kind = KIND_NOT_FOUND;
                    end
                end else if (r_found) begin
                    n_state = ST_FIRE;
                end else begin
                    n_state = ST_WAIT_OUT;
                end
            end
            ST_FIRE: begin
                n_ov   = 1'b1;
                n_kind = KIND_FIRED;
                n_eo   = r_bent.owner;
                n_ei   = r_bent.ident;
                n_last = 1'b0;
                n_fired[r_best] = 1'b1;
                if (r_bent.repeat_en) begin
                    wr_en   = 1'b1;
                    wr_data = r_bent;
                    wr_data.expiry = sat_add(r_now, r_bent.period);
                    wr_data.order  = r_counter;
                    n_counter = r_counter + 32'd1;
                end else begin
                    n_valid[r_best] = 1'b0;
                end
                n_cnt    = '0;
                n_found  = 1'b0;
                n_wfound = 1'b0;
                n_state  = ST_SCAN;
            end
            ST_WAIT_OUT: begin
                n_ov    = 1'b1;
                n_kind  = KIND_WAIT;
                n_wt    = (r_wfound && r_wmin > r_now) ? (r_wmin - r_now) : 32'd0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_counter <= '0;
            r_rdv     <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_counter <= n_counter;
            r_rdv     <= n_rdv;
            o_valid   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_cmd <= i_command;
            r_now <= i_now_ms;
            r_own <= i_owner;
            r_id  <= i_timer_id;
        end
        r_fired  <= n_fired;
        r_cnt    <= n_cnt;
        r_ridx   <= n_ridx;
        r_found  <= n_found;
        r_best   <= n_best;
        r_bent   <= n_bent;
        r_wfound <= n_wfound;
        r_wmin   <= n_wmin;
        o_kind        <= n_kind;
        o_event_owner <= n_eo;
        o_event_id    <= n_ei;
        o_wait_ms     <= n_wt;
        o_last        <= n_last;
    end

endmodule
